>>> hw/rtl/vqbd_pkg.sv
// Package for the vector-quantization block decoder: widths, codes, reset values
// and the structs shared by the front end, the back end and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vqbd_pkg;

   // Defaults for the top-level parameters
   localparam int DICT_ENTRIES_DEFAULT   = 256;
   localparam int MAX_BLOCK_SIDE_DEFAULT = 8;

   // Fixed by the field widths of the channels
   localparam int PIXEL_BITS  = 16;
   localparam int COORD_BITS  = 12;
   localparam int SIDE_W      = 4;
   localparam int SIZE_W      = COORD_BITS + 1;
   localparam int ENTRY_W     = 8;
   localparam int ELEMENT_W   = 6;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = SIZE_W;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 2 * COORD_BITS + 2 * PIXEL_BITS;

   // Image limit: sizes above this act as this
   localparam logic [SIZE_W-1:0] COORD_LIMIT = SIZE_W'(2 ** COORD_BITS);

   // Command queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Command codes on the request channel
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_TILE_WIDTH    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TILE_HEIGHT   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_COLUMNS = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_LINES   = 2'd3;

   // Configuration reset values
   localparam logic [SIDE_W-1:0] TILE_WIDTH_RESET    = 4'd4;
   localparam logic [SIDE_W-1:0] TILE_HEIGHT_RESET   = 4'd4;
   localparam logic [SIZE_W-1:0] IMAGE_COLUMNS_RESET = 13'd512;
   localparam logic [SIZE_W-1:0] IMAGE_LINES_RESET   = 13'd512;

   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_LOAD,
      KIND_DECODE
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic                  first;
      logic                  entry_ok;
      logic [PIXEL_BITS-1:0] value;
   } queue_ctl_type;

   typedef struct packed {
      logic [SIDE_W-1:0] tile_width;
      logic [SIDE_W-1:0] tile_height;
      logic [SIZE_W-1:0] image_columns;
      logic [SIZE_W-1:0] image_lines;
   } cfg_type;

endpackage

`default_nettype wire

>>> hw/rtl/vq_block_image_decoder_core.sv
// Top level of the vector-quantization block decoder: configuration registers,
// front end with command queue, back end and dictionary RAM.
// Uses vqbd_pkg, vqbd_front, vqbd_back and vqbd_ram.
//
//   Channel | Direction | Handshake             | Contents
//   req     | in        | req_tvalid/req_tready | load or decode command
//   rsp     | out       | rsp_tvalid/rsp_tready | one decoded pixel with its position
//   csr     | in        | csr_we                | block and image sizes, no read-back
//
// A load is written into the dictionary as the back end takes it from the queue. A
// decode reads block width times block height pixels: a set-up step, then one pixel
// per cycle while the result path can take it, set by the single read port of the
// dictionary RAM. Each pixel passes the RAM read register and the result register.
// Reset is synchronous and clears control state only; the dictionary holds no
// valid bits and needs no clearing pass. The four-entry command queue keeps
// taking requests until full while results stall, and a stalled result holds.
`timescale 1ns / 1ps
`default_nettype none

module vq_block_image_decoder_core #(
   parameter int DICT_ENTRIES   = vqbd_pkg::DICT_ENTRIES_DEFAULT,
   parameter int MAX_BLOCK_SIDE = vqbd_pkg::MAX_BLOCK_SIDE_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // csr
   input  wire logic                              csr_we,
   input  wire logic [vqbd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [vqbd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // req
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: entry [7:0], element [13:8], pixel_value [29:14], zero [31:30]
   input  wire logic [vqbd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: command [0], first_block [1]
   input  wire logic [vqbd_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // rsp
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: row [11:0], column [23:12], pixel [39:24], max_gray [55:40]
   output logic      [vqbd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // tlast: last_of_block
   output logic                                   rsp_tlast,
   // tuser: frame_end
   output logic                                   rsp_tuser
);

   import vqbd_pkg::*;

   localparam int SLOTS  = MAX_BLOCK_SIDE * MAX_BLOCK_SIDE;
   localparam int DEPTH  = DICT_ENTRIES * SLOTS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cfg_type cfg_ff, cfg_in;

   logic                  q_valid;
   logic                  q_ready;
   queue_ctl_type         q_ctl;
   logic [ADDR_W-1:0]     q_addr;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [PIXEL_BITS-1:0] ram_wdata;
   logic                  ram_re;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [PIXEL_BITS-1:0] ram_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_TILE_WIDTH:    cfg_in.tile_width    = csr_wdata[SIDE_W-1:0];
            CSR_TILE_HEIGHT:   cfg_in.tile_height   = csr_wdata[SIDE_W-1:0];
            CSR_IMAGE_COLUMNS: cfg_in.image_columns = csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_LINES:   cfg_in.image_lines   = csr_wdata[SIZE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_width    <= TILE_WIDTH_RESET;
         cfg_ff.tile_height   <= TILE_HEIGHT_RESET;
         cfg_ff.image_columns <= IMAGE_COLUMNS_RESET;
         cfg_ff.image_lines   <= IMAGE_LINES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vqbd_front #(
      .DICT_ENTRIES   (DICT_ENTRIES),
      .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_ctl      (q_ctl),
      .q_addr     (q_addr)
   );

   vqbd_back #(
      .DICT_ENTRIES   (DICT_ENTRIES),
      .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_ctl      (q_ctl),
      .q_addr     (q_addr),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   vqbd_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_dictionary (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

>>> hw/rtl/vqbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module vqbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vqbd_front.sv
// Front end: accepts request transactions, classifies them, works out the
// dictionary address and holds them in a short command queue. Uses vqbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vqbd_front #(
   parameter int DICT_ENTRIES   = vqbd_pkg::DICT_ENTRIES_DEFAULT,
   parameter int MAX_BLOCK_SIDE = vqbd_pkg::MAX_BLOCK_SIDE_DEFAULT,
   localparam int SLOTS  = MAX_BLOCK_SIDE * MAX_BLOCK_SIDE,
   localparam int ADDR_W = (DICT_ENTRIES * SLOTS > 1) ? $clog2(DICT_ENTRIES * SLOTS) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [vqbd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic [vqbd_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                                    q_valid,
   input  wire logic                               q_ready,
   output vqbd_pkg::queue_ctl_type                 q_ctl,
   output logic      [ADDR_W-1:0]                  q_addr
);

   import vqbd_pkg::*;

   logic                  command;
   logic                  first;
   logic [ENTRY_W-1:0]    entry;
   logic [ELEMENT_W-1:0]  element;
   logic [PIXEL_BITS-1:0] value;
   logic                  entry_ok;
   logic                  element_ok;
   queue_ctl_type         push_ctl;
   logic [ADDR_W-1:0]     push_addr;
   logic                  push;
   logic                  pop;

   queue_ctl_type         q_ctl_ff [QUEUE_DEPTH];
   logic [ADDR_W-1:0]     q_addr_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;

   assign command = req_tuser[0];
   assign first   = req_tuser[1];
   assign entry   = req_tdata[7:0];
   assign element = req_tdata[13:8];
   assign value   = req_tdata[29:14];

   assign entry_ok   = int'(entry) < DICT_ENTRIES;
   assign element_ok = int'(element) < SLOTS;

   // A load whose entry or element is out of range is turned into a skip here, so the
   // back end only drops it from the queue.
   always_comb begin
      push_ctl.first    = first;
      push_ctl.entry_ok = entry_ok;
      push_ctl.value    = value;
      if (command == OP_DECODE) begin
         push_ctl.kind = KIND_DECODE;
         push_addr     = ADDR_W'(entry) * ADDR_W'(SLOTS);
      end else begin
         push_ctl.kind = (entry_ok && element_ok) ? KIND_LOAD : KIND_SKIP;
         push_addr     = ADDR_W'(entry) * ADDR_W'(SLOTS) + ADDR_W'(element);
      end
   end

   assign req_tready = count_ff < (QPTR_W + 1)'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = count_ff != '0;
   assign pop        = q_valid && q_ready;
   assign q_ctl      = q_ctl_ff[rd_ptr_ff];
   assign q_addr     = q_addr_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ctl_ff[wr_ptr_ff]  <= push_ctl;
         q_addr_ff[wr_ptr_ff] <= push_addr;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/vqbd_back.sv
// Back end: takes commands from the queue, writes loads into the dictionary
// and sequences decodes one pixel per cycle, unless the result stalls, through the
// dictionary read port, with the block origin, the running maximum and the result register.
// Uses vqbd_pkg; drives the ports of a vqbd_ram instance.
`timescale 1ns / 1ps
`default_nettype none

module vqbd_back #(
   parameter int DICT_ENTRIES   = vqbd_pkg::DICT_ENTRIES_DEFAULT,
   parameter int MAX_BLOCK_SIDE = vqbd_pkg::MAX_BLOCK_SIDE_DEFAULT,
   localparam int SLOTS  = MAX_BLOCK_SIDE * MAX_BLOCK_SIDE,
   localparam int ADDR_W = (DICT_ENTRIES * SLOTS > 1) ? $clog2(DICT_ENTRIES * SLOTS) : 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire vqbd_pkg::cfg_type                   cfg,
   input  wire logic                                q_valid,
   output logic                                     q_ready,
   input  wire vqbd_pkg::queue_ctl_type             q_ctl,
   input  wire logic [ADDR_W-1:0]                   q_addr,
   output logic                                     ram_we,
   output logic      [ADDR_W-1:0]                   ram_waddr,
   output logic      [vqbd_pkg::PIXEL_BITS-1:0]     ram_wdata,
   output logic                                     ram_re,
   output logic      [ADDR_W-1:0]                   ram_raddr,
   input  wire logic [vqbd_pkg::PIXEL_BITS-1:0]     ram_rdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [vqbd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tuser
);

   import vqbd_pkg::*;

   localparam int SUM_W = SIZE_W + 1;

   back_state_type state_ff, state_in;

   logic [SIDE_W-1:0] bw_c, bh_c;
   logic [SIZE_W-1:0] cols_c, lines_c;

   logic issue, adv, setup, last_pix, k_last;
   logic [COORD_BITS-1:0] o_r, o_c;
   logic row_last, frame_last;

   // Origin and running maximum
   logic [COORD_BITS-1:0] origin_row_ff, origin_row_in;
   logic [COORD_BITS-1:0] origin_col_ff, origin_col_in;
   logic [PIXEL_BITS-1:0] running_max_ff, running_max_in;

   // Sequencer
   logic [SIDE_W-1:0]     j_ff, j_in, k_ff, k_in;
   logic [COORD_BITS-1:0] row_ff, row_in, col_ff, col_in, base_col_ff, base_col_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  ent_ok_ff, ent_ok_in;
   logic                  frame_last_ff, frame_last_in;
   logic                  clr_ff, clr_in;

   // Read stage: RAM data arrives with these tags
   logic                  s1_valid_ff, s1_valid_in;
   logic [COORD_BITS-1:0] s1_row_ff, s1_row_in, s1_col_ff, s1_col_in;
   logic                  s1_last_ff, s1_last_in, s1_frame_ff, s1_frame_in;
   logic                  s1_ok_ff, s1_ok_in, s1_clr_ff, s1_clr_in;

   // Result register
   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [PIXEL_BITS-1:0] out_pix_ff, out_pix_in, out_max_ff, out_max_in;
   logic                  out_last_ff, out_last_in, out_frame_ff, out_frame_in;

   logic [PIXEL_BITS-1:0] pix, max_base, max_new;

   // Out-of-range sizes are pulled back into range
   always_comb begin
      if (cfg.tile_width == '0) begin
         bw_c = SIDE_W'(1);
      end else if (int'(cfg.tile_width) > MAX_BLOCK_SIDE) begin
         bw_c = SIDE_W'(MAX_BLOCK_SIDE);
      end else begin
         bw_c = cfg.tile_width;
      end
      if (cfg.tile_height == '0) begin
         bh_c = SIDE_W'(1);
      end else if (int'(cfg.tile_height) > MAX_BLOCK_SIDE) begin
         bh_c = SIDE_W'(MAX_BLOCK_SIDE);
      end else begin
         bh_c = cfg.tile_height;
      end
      if (cfg.image_columns == '0) begin
         cols_c = SIZE_W'(1);
      end else if (cfg.image_columns > COORD_LIMIT) begin
         cols_c = COORD_LIMIT;
      end else begin
         cols_c = cfg.image_columns;
      end
      if (cfg.image_lines == '0) begin
         lines_c = SIZE_W'(1);
      end else if (cfg.image_lines > COORD_LIMIT) begin
         lines_c = COORD_LIMIT;
      end else begin
         lines_c = cfg.image_lines;
      end
   end

   assign adv      = !out_valid_ff || rsp_tready;
   assign k_last   = k_ff == bw_c - SIDE_W'(1);
   assign last_pix = k_last && (j_ff == bh_c - SIDE_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && q_ctl.kind == KIND_DECODE) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (issue && last_pix) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      q_ready = 1'b0;
      ram_we  = 1'b0;
      issue   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            q_ready = 1'b1;
            ram_we  = q_valid && q_ctl.kind == KIND_LOAD;
         end
         BK_RUN: begin
            // A new read only when the word now in the read register can move on
            issue = !s1_valid_ff || adv;
         end
         default: begin
            q_ready = 1'b0;
         end
      endcase
   end

   assign ram_re    = issue;
   assign ram_raddr = addr_ff;
   assign ram_waddr = q_addr;
   assign ram_wdata = q_ctl.value;
   assign setup     = q_ready && q_valid && q_ctl.kind == KIND_DECODE;

   // Block placement for the decode at the head of the queue
   always_comb begin
      o_r = q_ctl.first ? '0 : origin_row_ff;
      o_c = q_ctl.first ? '0 : origin_col_ff;
      row_last = SUM_W'(o_c) + SUM_W'(bw_c) >= SUM_W'(cols_c);
      frame_last = row_last && (SUM_W'(o_r) + SUM_W'(bh_c) >= SUM_W'(lines_c));
   end

   assign pix      = s1_ok_ff ? ram_rdata : '0;
   assign max_base = s1_clr_ff ? '0 : running_max_ff;
   assign max_new  = (pix > max_base) ? pix : max_base;

   always_comb begin
      origin_row_in  = origin_row_ff;
      origin_col_in  = origin_col_ff;
      running_max_in = running_max_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      base_col_in    = base_col_ff;
      addr_in        = addr_ff;
      ent_ok_in      = ent_ok_ff;
      frame_last_in  = frame_last_ff;
      clr_in         = clr_ff;
      s1_valid_in    = s1_valid_ff;
      s1_row_in      = s1_row_ff;
      s1_col_in      = s1_col_ff;
      s1_last_in     = s1_last_ff;
      s1_frame_in    = s1_frame_ff;
      s1_ok_in       = s1_ok_ff;
      s1_clr_in      = s1_clr_ff;
      out_valid_in   = out_valid_ff;
      out_row_in     = out_row_ff;
      out_col_in     = out_col_ff;
      out_pix_in     = out_pix_ff;
      out_max_in     = out_max_ff;
      out_last_in    = out_last_ff;
      out_frame_in   = out_frame_ff;

      if (setup) begin
         j_in          = '0;
         k_in          = '0;
         row_in        = o_r;
         col_in        = o_c;
         base_col_in   = o_c;
         addr_in       = q_addr;
         ent_ok_in     = q_ctl.entry_ok;
         frame_last_in = frame_last;
         clr_in        = q_ctl.first;
         if (frame_last) begin
            origin_row_in = '0;
            origin_col_in = '0;
         end else if (row_last) begin
            origin_row_in = o_r + COORD_BITS'(bh_c);
            origin_col_in = '0;
         end else begin
            origin_row_in = o_r;
            origin_col_in = o_c + COORD_BITS'(bw_c);
         end
      end

      if (s1_valid_ff && adv) begin
         out_row_in     = s1_row_ff;
         out_col_in     = s1_col_ff;
         out_pix_in     = pix;
         out_max_in     = max_new;
         out_last_in    = s1_last_ff;
         out_frame_in   = s1_frame_ff;
         running_max_in = max_new;
      end
      if (adv) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end

      if (issue) begin
         s1_valid_in = 1'b1;
         s1_row_in   = row_ff;
         s1_col_in   = col_ff;
         s1_last_in  = last_pix;
         s1_frame_in = last_pix && frame_last_ff;
         s1_ok_in    = ent_ok_ff;
         s1_clr_in   = clr_ff;
         clr_in      = 1'b0;
         addr_in     = addr_ff + ADDR_W'(1);
         if (k_last) begin
            k_in   = '0;
            j_in   = j_ff + SIDE_W'(1);
            col_in = base_col_ff;
            row_in = row_ff + COORD_BITS'(1);
         end else begin
            k_in   = k_ff + SIDE_W'(1);
            col_in = col_ff + COORD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         origin_row_ff  <= '0;
         origin_col_ff  <= '0;
         running_max_ff <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         origin_row_ff  <= origin_row_in;
         origin_col_ff  <= origin_col_in;
         running_max_ff <= running_max_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      k_ff          <= k_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      base_col_ff   <= base_col_in;
      addr_ff       <= addr_in;
      ent_ok_ff     <= ent_ok_in;
      frame_last_ff <= frame_last_in;
      clr_ff        <= clr_in;
      s1_row_ff     <= s1_row_in;
      s1_col_ff     <= s1_col_in;
      s1_last_ff    <= s1_last_in;
      s1_frame_ff   <= s1_frame_in;
      s1_ok_ff      <= s1_ok_in;
      s1_clr_ff     <= s1_clr_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_pix_ff    <= out_pix_in;
      out_max_ff    <= out_max_in;
      out_last_ff   <= out_last_in;
      out_frame_ff  <= out_frame_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_max_ff, out_pix_ff, out_col_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_frame_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vqbd_checker.sv
// Port-level checks for the block decoder top level, attached by a bind.
// Uses vqbd_pkg; binds to vq_block_image_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

module vqbd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [vqbd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic                              rsp_tlast,
   input wire logic                              rsp_tuser
);

   import vqbd_pkg::*;

   // A result held back by the consumer stays as it is.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result transaction changed");

   // The end of the image always falls on the last pixel of a block.
   a_frame_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without block end");

   // The running maximum includes the pixel it travels with.
   a_max_covers_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:RSP_TDATA_W-PIXEL_BITS]
         >= rsp_tdata[2*COORD_BITS+PIXEL_BITS-1:2*COORD_BITS])
      else $error("max_gray below pixel");

   // Nothing is offered on the result channel straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind vq_block_image_decoder_core vqbd_checker u_vqbd_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for vq_block_image_decoder_core: a scoreboard class mirrors the
// dictionary, the block origin and the running maximum, and checks every decoded pixel.
// Depends on vqbd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module testbench;
   import vqbd_pkg::*;

   localparam int ENTRIES       = DICT_ENTRIES_DEFAULT;
   localparam int SIDE_MAX      = MAX_BLOCK_SIDE_DEFAULT;
   localparam int SLOTS         = SIDE_MAX * SIDE_MAX;
   localparam int RANDOM_ITEMS  = 230;
   localparam int PHASE_ITEMS   = 40;
   localparam int SWEEP_DECODES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 20;
   localparam int IDLE_LIMIT    = 3000;

   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] column;
      logic [PIXEL_BITS-1:0] pixel;
      logic [PIXEL_BITS-1:0] gray_max;
      logic                  last_of_block;
      logic                  frame_end;
   } decoded_pixel_type;

   class pixel_scoreboard;
      logic [PIXEL_BITS-1:0] gray_store [ENTRIES*SLOTS];
      bit [SLOTS-1:0]        loaded_slots [ENTRIES];
      logic [SIDE_W-1:0]     width_reg;
      logic [SIDE_W-1:0]     height_reg;
      logic [SIZE_W-1:0]     columns_reg;
      logic [SIZE_W-1:0]     lines_reg;
      int unsigned           origin_row;
      int unsigned           origin_column;
      logic [PIXEL_BITS-1:0] peak_gray;
      decoded_pixel_type     pending_pixels [$];
      int unsigned           mismatches;

      function new();
         width_reg     = TILE_WIDTH_RESET;
         height_reg    = TILE_HEIGHT_RESET;
         columns_reg   = IMAGE_COLUMNS_RESET;
         lines_reg     = IMAGE_LINES_RESET;
         origin_row    = 0;
         origin_column = 0;
         peak_gray     = '0;
         mismatches    = 0;
         foreach (loaded_slots[i]) loaded_slots[i] = '0;
      endfunction

      function int unsigned side(logic [SIDE_W-1:0] raw);
         if (raw == 0) return 1;
         if (raw > SIDE_MAX) return SIDE_MAX;
         return 32'(raw);
      endfunction

      function int unsigned extent(logic [SIZE_W-1:0] raw);
         if (raw == 0) return 1;
         if (raw > COORD_LIMIT) return 32'(COORD_LIMIT);
         return 32'(raw);
      endfunction

      function void set_register(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_TILE_WIDTH:    width_reg   = data[SIDE_W-1:0];
            CSR_TILE_HEIGHT:   height_reg  = data[SIDE_W-1:0];
            CSR_IMAGE_COLUMNS: columns_reg = data[SIZE_W-1:0];
            CSR_IMAGE_LINES:   lines_reg   = data[SIZE_W-1:0];
            default:           ;
         endcase
      endfunction

      function int unsigned footprint();
         return side(width_reg) * side(height_reg);
      endfunction

      // An entry may be decoded only once every slot the current block shape reads is loaded.
      function bit entry_ready(int e);
         bit [SLOTS-1:0] mask;
         int unsigned n;
         n = footprint();
         mask = (n == SLOTS) ? '1 : ((SLOTS'(1) << n) - SLOTS'(1));
         return (loaded_slots[e] & mask) == mask;
      endfunction

      function int ready_entry();
         int e;
         for (int t = 0; t < 24; t++) begin
            e = $urandom_range(0, ENTRIES - 1);
            if (entry_ready(e)) return e;
         end
         for (e = 0; e < ENTRIES; e++)
            if (entry_ready(e)) return e;
         return -1;
      endfunction

      function void note_request(logic command, logic [ENTRY_W-1:0] entry,
                                 logic [ELEMENT_W-1:0] element,
                                 logic [PIXEL_BITS-1:0] value, logic first);
         int unsigned bw, bh, cols, lines;
         bit row_last, frame_last;
         decoded_pixel_type px;
         if (command == OP_LOAD) begin
            gray_store[entry * SLOTS + element] = value;
            loaded_slots[entry][element] = 1'b1;
            return;
         end
         bw    = side(width_reg);
         bh    = side(height_reg);
         cols  = extent(columns_reg);
         lines = extent(lines_reg);
         if (first) begin
            origin_row    = 0;
            origin_column = 0;
            peak_gray     = '0;
         end
         row_last   = (origin_column + bw >= cols);
         frame_last = row_last && (origin_row + bh >= lines);
         for (int j = 0; j < bh; j++) begin
            for (int k = 0; k < bw; k++) begin
               px.pixel = gray_store[entry * SLOTS + j * bw + k];
               if (px.pixel > peak_gray) peak_gray = px.pixel;
               px.row           = COORD_BITS'(origin_row + j);
               px.column        = COORD_BITS'(origin_column + k);
               px.gray_max      = peak_gray;
               px.last_of_block = (j == bh - 1) && (k == bw - 1);
               px.frame_end     = px.last_of_block && frame_last;
               pending_pixels.push_back(px);
            end
         end
         if (frame_last) begin
            origin_row    = 0;
            origin_column = 0;
         end else if (row_last) begin
            origin_column = 0;
            origin_row    = origin_row + bh;
         end else begin
            origin_column = origin_column + bw;
         end
      endfunction

      task report(string text);
         mismatches++;
         $display("%0t ns: %s", $time, text);
      endtask

      task check_pixel(logic [RSP_TDATA_W-1:0] data, logic last, logic frame);
         decoded_pixel_type got;
         decoded_pixel_type want;
         got.row           = data[COORD_BITS-1:0];
         got.column        = data[2*COORD_BITS-1:COORD_BITS];
         got.pixel         = data[2*COORD_BITS +: PIXEL_BITS];
         got.gray_max      = data[2*COORD_BITS+PIXEL_BITS +: PIXEL_BITS];
         got.last_of_block = last;
         got.frame_end     = frame;
         if (pending_pixels.size() == 0) begin
            report($sformatf("pixel with none expected: row %0d column %0d pixel %h",
                             got.row, got.column, got.pixel));
            return;
         end
         want = pending_pixels.pop_front();
         if (got.row !== want.row || got.column !== want.column || got.pixel !== want.pixel
             || got.gray_max !== want.gray_max || got.last_of_block !== want.last_of_block
             || got.frame_end !== want.frame_end)
            report($sformatf(
               "pixel mismatch row %0d/%0d col %0d/%0d pix %h/%h max %h/%h last %b/%b end %b/%b",
               got.row, want.row, got.column, want.column, got.pixel, want.pixel,
               got.gray_max, want.gray_max, got.last_of_block, want.last_of_block,
               got.frame_end, want.frame_end));
      endtask
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_we      = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [REQ_TUSER_W-1:0] req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;

   pixel_scoreboard sb;
   int  requests_sent = 0;
   bit  quiet_phase   = 1'b0;
   bit  hold_request  = 1'b0;

   vq_block_image_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly no gap, sometimes a short one and now and then a long one.
   function automatic int gap_length();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] random_gray();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return PIXEL_BITS'($urandom);
   endfunction

   function automatic logic [SIDE_W-1:0] pick_side();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return SIDE_W'($urandom_range(1, 4));
      if (r < 80) return SIDE_W'($urandom_range(5, SIDE_MAX));
      if (r < 90) return '0;
      return SIDE_W'($urandom_range(SIDE_MAX + 1, 15));
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size(int unsigned stride);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return COORD_LIMIT;
      if (r == 3) return SIZE_W'(stride * $urandom_range(1, 4) + $urandom_range(0, stride - 1));
      return SIZE_W'(stride * $urandom_range(1, 4));
   endfunction

   task automatic send_request(input logic command, input logic [ENTRY_W-1:0] entry,
                               input logic [ELEMENT_W-1:0] element,
                               input logic [PIXEL_BITS-1:0] value, input logic first);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, value, element, entry};
      req_tuser  <= {first, command};
      do @(posedge clock); while (!req_tready);
      sb.note_request(command, entry, element, value, first);
      requests_sent++;
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(index, data);
   endtask

   // Registers change only once the decoder has drained; trailing loads leave no
   // result behind, hence the extra settling cycles.
   task automatic configure(input logic [SIDE_W-1:0] bw, input logic [SIDE_W-1:0] bh,
                            input logic [SIZE_W-1:0] cols, input logic [SIZE_W-1:0] lines);
      req_tvalid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_TILE_WIDTH, CSR_DATA_W'(bw));
      write_register(CSR_TILE_HEIGHT, CSR_DATA_W'(bh));
      write_register(CSR_IMAGE_COLUMNS, cols);
      write_register(CSR_IMAGE_LINES, lines);
      csr_we <= 1'b0;
   endtask

   task automatic load_block(input int e);
      int n;
      int start;
      n = sb.footprint();
      start = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++)
         send_request(OP_LOAD, ENTRY_W'(e), ELEMENT_W'((start + i) % n), random_gray(),
                      1'($urandom_range(0, 1)));
   endtask

   task automatic decode_ready(input logic first);
      int e;
      e = sb.ready_entry();
      if (e < 0) begin
         e = $urandom_range(0, ENTRIES - 1);
         load_block(e);
      end
      send_request(OP_DECODE, ENTRY_W'(e), ELEMENT_W'($urandom), PIXEL_BITS'($urandom), first);
   endtask

   task automatic random_burst();
      int r;
      int e;
      r = $urandom_range(0, 99);
      e = $urandom_range(0, ENTRIES - 1);
      if (r < 45) begin
         load_block(e);
         repeat ($urandom_range(1, 3))
            send_request(OP_DECODE, ENTRY_W'(e), ELEMENT_W'($urandom), PIXEL_BITS'($urandom),
                         $urandom_range(0, 7) == 0);
      end else if (r < 80) begin
         decode_ready($urandom_range(0, 7) == 0);
      end else if (r < 90) begin
         send_request(OP_LOAD, ENTRY_W'(e), ELEMENT_W'($urandom), random_gray(),
                      1'($urandom_range(0, 1)));
      end else begin
         // Broken sequence: a partly loaded block, then a decode of something else.
         repeat ($urandom_range(0, sb.footprint() - 1))
            send_request(OP_LOAD, ENTRY_W'(e),
                         ELEMENT_W'($urandom_range(0, sb.footprint() - 1)),
                         random_gray(), 1'b0);
         decode_ready($urandom_range(0, 1) == 1);
      end
   endtask

   // Result side: check every transaction, then choose tready for the next cycle.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_pixel(rsp_tdata, rsp_tlast, rsp_tuser);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end else if (stall_left == 0) begin
            stall_left = gap_length();
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int random_start;
      int phase_end;
      int phase;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset shape: 4x4 blocks; extreme grays and running-maximum behaviour.
      for (int s = 0; s < 16; s++)
         send_request(OP_LOAD, ENTRY_W'(0), ELEMENT_W'(s),
                      (s == 0) ? 16'h1234 : (s == 3) ? 16'hFFFF : (s == 15) ? 16'h0000
                                                                           : random_gray(),
                      1'b0);
      send_request(OP_DECODE, 8'd0, 6'd63, 16'hFFFF, 1'b1);
      send_request(OP_DECODE, 8'd0, 6'd0, 16'h0000, 1'b0);

      // Zero sizes act as one: every block is a whole frame.
      configure('0, '0, '0, '0);
      send_request(OP_LOAD, 8'd255, 6'd63, 16'hFFFF, 1'b1);
      send_request(OP_LOAD, 8'd255, 6'd0, 16'h8000, 1'b1);
      send_request(OP_DECODE, 8'd255, 6'd0, 16'h0000, 1'b0);
      send_request(OP_DECODE, 8'd255, 6'd63, 16'hFFFF, 1'b1);
      send_request(OP_DECODE, 8'd0, 6'd21, 16'h5555, 1'b0);

      // Walk a one-column image whose height is not a multiple of the block, so the
      // last block runs past the edge and the origin wraps; the receiver holds off
      // at the start.
      configure(SIDE_W'(1), SIDE_W'(7), SIZE_W'(1), SIZE_W'(100));
      quiet_phase  = 1'b1;
      hold_request = 1'b1;
      for (int i = 0; i < SWEEP_DECODES; i++)
         send_request(OP_DECODE, 8'd0, ELEMENT_W'($urandom), PIXEL_BITS'($urandom), i == 0);
      quiet_phase = 1'b0;

      random_start = requests_sent;
      phase = 0;
      while (requests_sent - random_start < RANDOM_ITEMS) begin
         if (phase == 0)
            configure(SIDE_W'(15), SIDE_W'(8), SIZE_W'(20), SIZE_W'(16));
         else if (phase == 1)
            configure(SIDE_W'(8), SIDE_W'(15), '1, '1);
         else begin
            logic [SIDE_W-1:0] bw;
            logic [SIDE_W-1:0] bh;
            bw = pick_side();
            bh = pick_side();
            configure(bw, bh, pick_size(sb.side(bw)), pick_size(sb.side(bh)));
         end
         quiet_phase = (phase == 3);
         phase_end = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_end) random_burst();
         phase++;
      end
      quiet_phase = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
